@@ hw/rtl/ppd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and helpers of the process priority decay block
// Record carried down the pipeline, register map and the arithmetic helpers
// for cpu usage decay and user priority recompute.
// ----------------------------------------------------------------------------
package ppd_pkg;

    // saturation limits
    localparam logic [6:0] TIME_SAT = 7'd127;

    // usage decay by 8/10 reaches zero from 255 in this many steps
    localparam int DECAY_STAGES = 21;
    localparam int CNT_W        = $clog2(DECAY_STAGES + 1);

    // register map, index taken from paddr[2]
    localparam logic REG_USER_PRI_BASE = 1'b0;
    localparam logic [6:0] USER_PRI_BASE_RST = 7'd50;

    // command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_WAKEUP = 1'b1;

    typedef struct packed {
        logic             wake;
        logic [7:0]       cpu;
        logic [5:0]       nice;
        logic [6:0]       pri;
        logic [6:0]       run_time;
        logic [6:0]       sleep_time;
        logic [15:0]      timer_count;
        logic             alarm;
        logic [6:0]       run_pri;
        logic [CNT_W-1:0] cnt;
        logic             recompute;
        logic             resched_en;
    } ppd_rec_t;

    // floor(c * 8 / 10) as c * 820 >> 10, exact over 0..255
    function automatic logic [7:0] cpu_decay(input logic [7:0] c);
        logic [17:0] p;
        p = 18'(c) * 18'd820;
        return p[17:10];
    endfunction

    // cpu / 16 + base + nice, clamped to 0..127
    function automatic logic [6:0] user_pri(input logic [7:0] c, input logic [5:0] n,
                                            input logic [6:0] b);
        logic signed [8:0] s;
        s = $signed({5'b0, c[7:4]}) + $signed({2'b0, b}) + $signed({{3{n[5]}}, n});
        if (s[8]) begin
            return 7'd0;
        end else if (s[7]) begin
            return 7'd127;
        end else begin
            return s[6:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/process_priority_decay.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// process_priority_decay: scheduler field update for one process record
// Once-a-second tick and wakeup recompute of cpu usage, user priority,
// run/sleep time and the real-time alarm count.
// ----------------------------------------------------------------------------
// A request enters on the s_ channel whenever s_tready is high, and its
// result leaves on the m_ channel once it has passed every stage. The
// pipeline takes a new request every cycle: one input stage does the tick
// arithmetic and sizes the wakeup decay, then a chain of 21 decay stages
// applies at most one cpu*8/10 step each (21 steps take any usage to zero),
// one stage recomputes the user priority and the output register settles
// the reschedule flag. While a result waits on a low m_tready the whole
// pipeline holds. The user priority base sits at APB byte address 0 and
// resets to 50; change it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module process_priority_decay
    import ppd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cpu_usage[7:0], nice_value[13:8], current_process_priority[20:14],
    // run_time[27:21], sleep_time[34:28], is_sleeping[35],
    // timer_count[51:36], timer_reload[67:52], running_priority[74:68]
    input  wire logic [79:0] s_tdata,
    // command[0]
    input  wire logic [0:0]  s_tuser,

    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // new_cpu_usage[7:0], new_priority[14:8], new_run_time[21:15],
    // new_sleep_time[28:22], new_timer_count[44:29], alarm_fired[45],
    // reschedule[46]
    output logic [47:0]      m_tdata,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [6:0] base_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_USER_PRI_BASE);
    assign prdata = (paddr[2] == REG_USER_PRI_BASE) ? {25'b0, base_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= USER_PRI_BASE_RST;
        end else if (cfg_wr) begin
            base_reg <= pwdata[6:0];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together unless the output stalls
    // ------------------------------------------------------------------
    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // input stage: tick arithmetic and wakeup decay count
    // ------------------------------------------------------------------
    logic        in_cmd;
    logic [7:0]  in_cpu;
    logic [5:0]  in_nice;
    logic [6:0]  in_pri;
    logic [6:0]  in_rt;
    logic [6:0]  in_st;
    logic        in_sleeping;
    logic [15:0] in_tc;
    logic [15:0] in_tr;
    logic [6:0]  in_run_pri;

    assign in_cmd      = s_tuser[0];
    assign in_cpu      = s_tdata[7:0];
    assign in_nice     = s_tdata[13:8];
    assign in_pri      = s_tdata[20:14];
    assign in_rt       = s_tdata[27:21];
    assign in_st       = s_tdata[34:28];
    assign in_sleeping = s_tdata[35];
    assign in_tc       = s_tdata[51:36];
    assign in_tr       = s_tdata[67:52];
    assign in_run_pri  = s_tdata[74:68];

    ppd_rec_t          s1_next;
    ppd_rec_t          s1_rec_reg;
    logic              s1_vld_reg;
    logic [6:0]        st_tick;
    logic [6:0]        st_less2;
    logic [15:0]       tc_dec;
    logic signed [9:0] tick_sum;

    always_comb begin
        st_tick  = (in_sleeping && (in_st != TIME_SAT)) ? in_st + 7'd1 : in_st;
        st_less2 = in_st - 7'd2;
        tc_dec   = in_tc - 16'd1;
        tick_sum = $signed({2'b0, cpu_decay(in_cpu)}) + $signed({{4{in_nice[5]}}, in_nice});

        s1_next             = '0;
        s1_next.wake        = (in_cmd == CMD_WAKEUP);
        s1_next.cpu         = in_cpu;
        s1_next.nice        = in_nice;
        s1_next.pri         = in_pri;
        s1_next.run_time    = in_rt;
        s1_next.sleep_time  = 7'd0;
        s1_next.timer_count = in_tc;
        s1_next.alarm       = 1'b0;
        s1_next.run_pri     = in_run_pri;
        s1_next.cnt         = '0;
        s1_next.recompute   = 1'b0;
        s1_next.resched_en  = 1'b0;

        case (in_cmd)
            CMD_TICK: begin
                s1_next.run_time   = (in_rt != TIME_SAT) ? in_rt + 7'd1 : in_rt;
                s1_next.sleep_time = st_tick;
                if (in_tc != 16'd0) begin
                    if (tc_dec == 16'd0) begin
                        s1_next.alarm       = 1'b1;
                        s1_next.timer_count = in_tr;
                    end else begin
                        s1_next.timer_count = tc_dec;
                    end
                end
                // one decay now if the new sleep time is at most one, none in the chain
                if (st_tick <= 7'd1) begin
                    if (tick_sum[9]) begin
                        s1_next.cpu = 8'd0;
                    end else if (tick_sum[8]) begin
                        s1_next.cpu = 8'd255;
                    end else begin
                        s1_next.cpu = tick_sum[7:0];
                    end
                    s1_next.recompute  = (in_pri >= base_reg);
                    s1_next.resched_en = (in_pri >= base_reg);
                end
            end
            CMD_WAKEUP: begin
                // one decay per second slept beyond the first two, capped at the chain length
                if (in_st > 7'd1) begin
                    s1_next.recompute = 1'b1;
                    s1_next.cnt = (st_less2 > 7'(DECAY_STAGES)) ? CNT_W'(DECAY_STAGES)
                                                                 : st_less2[CNT_W-1:0];
                end
                s1_next.resched_en = 1'b1;
            end
            default: begin
                s1_next.resched_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // decay chain: each stage applies one decay while its count is nonzero
    // ------------------------------------------------------------------
    ppd_rec_t dec_next    [DECAY_STAGES];
    ppd_rec_t dec_rec_reg [DECAY_STAGES];
    logic     dec_vld_reg [DECAY_STAGES];

    always_comb begin
        for (int k = 0; k < DECAY_STAGES; k++) begin
            dec_next[k] = (k == 0) ? s1_rec_reg : dec_rec_reg[(k == 0) ? 0 : k - 1];
            if (dec_next[k].cnt != '0) begin
                dec_next[k].cpu = cpu_decay(dec_next[k].cpu);
                dec_next[k].cnt = dec_next[k].cnt - CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // priority stage
    // ------------------------------------------------------------------
    ppd_rec_t pr_next;
    ppd_rec_t pr_rec_reg;
    logic     pr_vld_reg;

    always_comb begin
        pr_next = dec_rec_reg[DECAY_STAGES-1];
        if (pr_next.recompute) begin
            pr_next.pri = user_pri(pr_next.cpu, pr_next.nice, base_reg);
        end
    end

    // ------------------------------------------------------------------
    // output stage
    // ------------------------------------------------------------------
    ppd_rec_t out_rec_reg;
    logic     out_resched_reg;
    logic     out_resched_next;

    assign out_resched_next = pr_rec_reg.resched_en && (pr_rec_reg.pri < pr_rec_reg.run_pri);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            pr_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < DECAY_STAGES; k++) begin
                dec_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            s1_vld_reg     <= s_tvalid;
            dec_vld_reg[0] <= s1_vld_reg;
            for (int k = 1; k < DECAY_STAGES; k++) begin
                dec_vld_reg[k] <= dec_vld_reg[k-1];
            end
            pr_vld_reg  <= dec_vld_reg[DECAY_STAGES-1];
            m_valid_reg <= pr_vld_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_rec_reg <= s1_next;
            for (int k = 0; k < DECAY_STAGES; k++) begin
                dec_rec_reg[k] <= dec_next[k];
            end
            pr_rec_reg      <= pr_next;
            out_rec_reg     <= pr_rec_reg;
            out_resched_reg <= out_resched_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0,
                       out_resched_reg,
                       out_rec_reg.alarm,
                       out_rec_reg.timer_count,
                       out_rec_reg.sleep_time,
                       out_rec_reg.run_time,
                       out_rec_reg.pri,
                       out_rec_reg.cpu};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // wakeup decay count never exceeds the chain length
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg |-> (s1_rec_reg.cnt <= CNT_W'(DECAY_STAGES)))
        else $error("decay count exceeds chain length");

    // every decay has been applied by the end of the chain
    a_cnt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        pr_vld_reg |-> (pr_rec_reg.cnt == '0))
        else $error("decay count left at end of chain");

    // a wakeup clears sleep time and never fires the alarm
    a_wake_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_rec_reg.wake) |->
            (out_rec_reg.sleep_time == 7'd0 && !out_rec_reg.alarm))
        else $error("wakeup result has sleep time or alarm set");

    // reschedule only for a priority better than the running one
    a_resched: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_resched_reg) |-> (out_rec_reg.pri < out_rec_reg.run_pri))
        else $error("reschedule without better priority");

    // a stalled pipeline keeps its occupancy
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(s1_vld_reg) && $stable(pr_vld_reg)
                  && $stable(dec_vld_reg[DECAY_STAGES-1])))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
